// File: rtl/pssd_pkg.sv
package pssd_pkg;

    // default coordinate width, signed fixed point
    localparam int COORD_WIDTH_DEF = 32;

    // quotient bits of the projection parameter t
    localparam int DIV_STEPS = 32;

    // region codes of a result item
    localparam logic [1:0] REGION_FIRST  = 2'd0;
    localparam logic [1:0] REGION_SECOND = 2'd1;
    localparam logic [1:0] REGION_INSIDE = 2'd2;

endpackage

// File: rtl/pssd_in_if.sv
interface pssd_in_if #(
    parameter int COORD_WIDTH = pssd_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        output ready
    );
endinterface

// File: rtl/pssd_out_if.sv
interface pssd_out_if #(
    parameter int COORD_WIDTH = pssd_pkg::COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH:0]   distance;
    logic [1:0]             region;

    modport source (
        output valid, distance, region,
        input  ready
    );
    modport sink (
        input  valid, distance, region,
        output ready
    );
endinterface

// File: rtl/pssd_div_cell.sv
module pssd_div_cell #(
    parameter int SW = 68,
    parameter int TW = 32,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_rem,
    input  logic [SW-1:0] i_den,
    input  logic [TW-1:0] i_quo,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [SW-1:0] o_rem,
    output logic [SW-1:0] o_den,
    output logic [TW-1:0] o_quo,
    output logic [PW-1:0] o_side
);
    logic [SW:0]   shifted;
    logic          take;
    logic [SW-1:0] n_rem;

    // one restoring step: shift in a zero, subtract the divisor if it fits
    always_comb begin
        shifted = {i_rem, 1'b0};
        take    = shifted >= {1'b0, i_den};
        n_rem   = take ? SW'(shifted - {1'b0, i_den}) : shifted[SW-1:0];
    end

    logic          r_valid;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_den;
    logic [TW-1:0] r_quo;
    logic [PW-1:0] r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_rem   <= n_rem;
            r_den   <= i_den;
            r_quo   <= {i_quo[TW-2:0], take};
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;
endmodule

// File: rtl/pssd_sqrt_cell.sv
module pssd_sqrt_cell #(
    parameter int NW  = 68,
    parameter int RW  = 33,
    parameter int BIT = 0,
    parameter int PW  = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rad,
    input  logic [RW-1:0] i_root,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_rad,
    output logic [RW-1:0] o_root,
    output logic [PW-1:0] o_side
);
    logic [NW-1:0] trial;
    logic          take;

    // rad holds n - root^2; setting this bit adds root*2^(b+1) + 2^(2b)
    always_comb begin
        trial = (NW'(i_root) << (BIT + 1)) | (NW'(1) << (2 * BIT));
        take  = i_rad >= trial;
    end

    logic          r_valid;
    logic [NW-1:0] r_rad;
    logic [RW-1:0] r_root;
    logic [PW-1:0] r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_rad   <= take ? (i_rad - trial) : i_rad;
            r_root  <= take ? (i_root | (RW'(1) << BIT)) : i_root;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_root  = r_root;
    assign o_side  = r_side;
endmodule

// File: rtl/point_segment_distance_3d.sv
// Distance from a query point to a 3D line segment, all coordinates signed fixed point.
// A fully pipelined datapath takes one item per clock unless stalled and gives one
// result item per item, in order. Its depth is set by a chain of 32 divider cells,
// one quotient bit each, that forms the projection parameter, and a chain of
// COORD_WIDTH+1 square root cells, one result bit each. The output register and
// a one-item skid stage let the input keep flowing while a finished result waits;
// once the skid stage holds an item, a stalled output freezes the whole pipe.
// region: 0 nearest the first end, 1 nearest the second end, 2 interior point.
module point_segment_distance_3d #(
    parameter int COORD_WIDTH = pssd_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pssd_in_if.sink    i_seg,
    pssd_out_if.source o_dist
);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PWD = 2 * DW;
    localparam int SW  = 2 * DW + 2;
    localparam int TW  = pssd_pkg::DIV_STEPS;
    localparam int OW  = DW + TW + 1;
    localparam int FW  = OW - TW;
    localparam int EW  = CW + 2;
    localparam int RW  = CW + 1;
    localparam int NW  = 2 * EW;
    localparam int SPW = 2 + 6 * CW + 6 * DW;

    logic en;
    logic fire;

    // stage 1: differences
    logic [2:0][CW-1:0] in_p, in_a, in_b;
    logic               r_s1_valid;
    logic [2:0][CW-1:0] r_s1_p, r_s1_a;
    logic [2:0][DW-1:0] r_s1_v, r_s1_w, r_s1_e;

    assign in_p = {i_seg.point_z, i_seg.point_y, i_seg.point_x};
    assign in_a = {i_seg.start_z, i_seg.start_y, i_seg.start_x};
    assign in_b = {i_seg.end_z, i_seg.end_y, i_seg.end_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_seg.valid;
            for (int i = 0; i < 3; i++) begin
                r_s1_p[i] <= in_p[i];
                r_s1_a[i] <= in_a[i];
                r_s1_v[i] <= {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
                r_s1_w[i] <= {in_p[i][CW-1], in_p[i]} - {in_a[i][CW-1], in_a[i]};
                r_s1_e[i] <= {in_p[i][CW-1], in_p[i]} - {in_b[i][CW-1], in_b[i]};
            end
        end
    end

    // stage 2: per-axis products for the dot products
    logic                r_s2_valid;
    logic [2:0][CW-1:0]  r_s2_p, r_s2_a;
    logic [2:0][DW-1:0]  r_s2_v, r_s2_w, r_s2_e;
    logic [2:0][PWD-1:0] r_s2_wv, r_s2_vv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
            r_s2_p     <= r_s1_p;
            r_s2_a     <= r_s1_a;
            r_s2_v     <= r_s1_v;
            r_s2_w     <= r_s1_w;
            r_s2_e     <= r_s1_e;
            for (int i = 0; i < 3; i++) begin
                r_s2_wv[i] <= PWD'($signed(r_s1_w[i]) * $signed(r_s1_v[i]));
                r_s2_vv[i] <= PWD'($signed(r_s1_v[i]) * $signed(r_s1_v[i]));
            end
        end
    end

    // stage 3: c1 = w.v and c2 = v.v
    logic               r_s3_valid;
    logic [2:0][CW-1:0] r_s3_p, r_s3_a;
    logic [2:0][DW-1:0] r_s3_v, r_s3_w, r_s3_e;
    logic [SW-1:0]      r_s3_c1, r_s3_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
            r_s3_p     <= r_s2_p;
            r_s3_a     <= r_s2_a;
            r_s3_v     <= r_s2_v;
            r_s3_w     <= r_s2_w;
            r_s3_e     <= r_s2_e;
            r_s3_c1    <= SW'($signed(r_s2_wv[0])) + SW'($signed(r_s2_wv[1]))
                        + SW'($signed(r_s2_wv[2]));
            r_s3_c2    <= SW'(r_s2_vv[0]) + SW'(r_s2_vv[1]) + SW'(r_s2_vv[2]);
        end
    end

    // region decision and divider feed
    logic [1:0]         s3_region;
    logic [2:0][DW-1:0] s3_alt;
    logic [SW-1:0]      s3_rem;

    always_comb begin
        s3_alt = r_s3_w;
        s3_rem = '0;
        if (r_s3_c1[SW-1] || (r_s3_c1 == '0)) begin
            s3_region = pssd_pkg::REGION_FIRST;
        end else if ($signed(r_s3_c2) <= $signed(r_s3_c1)) begin
            s3_region = pssd_pkg::REGION_SECOND;
            s3_alt    = r_s3_e;
        end else begin
            s3_region = pssd_pkg::REGION_INSIDE;
            s3_rem    = r_s3_c1;
        end
    end

    // divider chain: t = floor(c1 * 2^32 / c2), one bit per cell
    logic                div_valid [0:TW];
    logic [SW-1:0]       div_rem   [0:TW];
    logic [SW-1:0]       div_den   [0:TW];
    logic [TW-1:0]       div_quo   [0:TW];
    logic [SPW-1:0]      div_side  [0:TW];

    assign div_valid[0] = r_s3_valid;
    assign div_rem[0]   = s3_rem;
    assign div_den[0]   = r_s3_c2;
    assign div_quo[0]   = '0;
    assign div_side[0]  = {s3_region, r_s3_p, r_s3_a, r_s3_v, s3_alt};

    for (genvar k = 0; k < TW; k++) begin : g_div
        pssd_div_cell #(.SW(SW), .TW(TW), .PW(SPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[k]),
            .i_rem   (div_rem[k]),
            .i_den   (div_den[k]),
            .i_quo   (div_quo[k]),
            .i_side  (div_side[k]),
            .o_valid (div_valid[k+1]),
            .o_rem   (div_rem[k+1]),
            .o_den   (div_den[k+1]),
            .o_quo   (div_quo[k+1]),
            .o_side  (div_side[k+1])
        );
    end

    logic [1:0]         dv_region;
    logic [2:0][CW-1:0] dv_p, dv_a;
    logic [2:0][DW-1:0] dv_v, dv_alt;

    assign {dv_region, dv_p, dv_a, dv_v, dv_alt} = div_side[TW];

    // stage 5: offset product t * v
    logic               r_s5_valid;
    logic [1:0]         r_s5_region;
    logic [2:0][CW-1:0] r_s5_p, r_s5_a;
    logic [2:0][DW-1:0] r_s5_alt;
    logic [2:0][OW-1:0] r_s5_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid  <= div_valid[TW];
            r_s5_region <= dv_region;
            r_s5_p      <= dv_p;
            r_s5_a      <= dv_a;
            r_s5_alt    <= dv_alt;
            for (int i = 0; i < 3; i++) begin
                r_s5_prod[i] <= OW'($signed(dv_v[i]) * $signed({1'b0, div_quo[TW]}));
            end
        end
    end

    // stage 6: difference to the nearest point
    logic [2:0][FW+1:0] s5_diff;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s5_diff[i] = (FW+2)'($signed(r_s5_p[i]))
                       - (FW+2)'($signed(r_s5_a[i]))
                       - (FW+2)'($signed(r_s5_prod[i][OW-1:TW]));
        end
    end

    logic               r_s6_valid;
    logic [1:0]         r_s6_region;
    logic [2:0][EW-1:0] r_s6_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (en) begin
            r_s6_valid  <= r_s5_valid;
            r_s6_region <= r_s5_region;
            for (int i = 0; i < 3; i++) begin
                if (r_s5_region == pssd_pkg::REGION_INSIDE) begin
                    r_s6_d[i] <= s5_diff[i][EW-1:0];
                end else begin
                    r_s6_d[i] <= EW'($signed(r_s5_alt[i]));
                end
            end
        end
    end

    // stage 7: squares
    logic               r_s7_valid;
    logic [1:0]         r_s7_region;
    logic [2:0][NW-1:0] r_s7_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (en) begin
            r_s7_valid  <= r_s6_valid;
            r_s7_region <= r_s6_region;
            for (int i = 0; i < 3; i++) begin
                r_s7_sq[i] <= NW'($signed(r_s6_d[i]) * $signed(r_s6_d[i]));
            end
        end
    end

    // stage 8: squared length
    logic          r_s8_valid;
    logic [1:0]    r_s8_region;
    logic [NW-1:0] r_s8_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (en) begin
            r_s8_valid  <= r_s7_valid;
            r_s8_region <= r_s7_region;
            r_s8_sum    <= r_s7_sq[0] + r_s7_sq[1] + r_s7_sq[2];
        end
    end

    // square root chain, most significant bit first
    logic          sq_valid [0:RW];
    logic [NW-1:0] sq_rad   [0:RW];
    logic [RW-1:0] sq_root  [0:RW];
    logic [1:0]    sq_side  [0:RW];

    assign sq_valid[0] = r_s8_valid;
    assign sq_rad[0]   = r_s8_sum;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = r_s8_region;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        pssd_sqrt_cell #(.NW(NW), .RW(RW), .BIT(RW - 1 - k), .PW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_rad   (sq_rad[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // output register with skid stage
    logic          r_out_valid;
    logic [RW-1:0] r_out_dist;
    logic [1:0]    r_out_region;
    logic          r_skid_valid;
    logic [RW-1:0] r_skid_dist;
    logic [1:0]    r_skid_region;

    assign en   = !r_skid_valid;
    assign fire = en && sq_valid[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (o_dist.ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_dist   <= r_skid_dist;
                r_out_region <= r_skid_region;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= fire;
                r_out_dist   <= sq_root[RW];
                r_out_region <= sq_side[RW];
            end
        end else if (fire) begin
            r_skid_valid  <= 1'b1;
            r_skid_dist   <= sq_root[RW];
            r_skid_region <= sq_side[RW];
        end
    end

    assign i_seg.ready     = en;
    assign o_dist.valid    = r_out_valid;
    assign o_dist.distance = r_out_dist;
    assign o_dist.region   = r_out_region;

    // skid stage only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item without output item");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !o_dist.ready |=> r_skid_valid)
        else $error("skid item lost while output stalled");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && o_dist.ready |=> r_out_valid && !r_skid_valid)
        else $error("skid item not moved to output");

endmodule

// File: verif/pssd_checker.sv
`timescale 1ns / 100ps

module pssd_checker #(
    parameter int COORD_WIDTH = pssd_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pssd_in_if.sink    i_seg,
    pssd_out_if.sink   i_dist,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [COORD_WIDTH:0] distance;
        logic [1:0]           region;
    } t_dist_item;

    t_dist_item expected_q[$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    // floor square root of a 128-bit unsigned value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    // distance to the nearest point of the segment and its region
    function automatic t_dist_item segment_distance(
        input logic signed [COORD_WIDTH-1:0] p [3],
        input logic signed [COORD_WIDTH-1:0] a [3],
        input logic signed [COORD_WIDTH-1:0] b [3]
    );
        logic signed [127:0] v [3];
        logic signed [127:0] w [3];
        logic signed [127:0] d [3];
        logic signed [127:0] c1;
        logic signed [127:0] c2;
        logic signed [127:0] prod;
        logic [127:0]        rem;
        logic [127:0]        sum;
        logic [63:0]         t;
        t_dist_item          res;
        c1 = 0;
        c2 = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = 128'(signed'(b[i])) - 128'(signed'(a[i]));
            w[i] = 128'(signed'(p[i])) - 128'(signed'(a[i]));
            c1 += w[i] * v[i];
            c2 += v[i] * v[i];
        end
        if (c1 <= 0) begin
            for (int i = 0; i < 3; i++) d[i] = w[i];
            res.region = pssd_pkg::REGION_FIRST;
        end else if (c2 <= c1) begin
            for (int i = 0; i < 3; i++)
                d[i] = 128'(signed'(p[i])) - 128'(signed'(b[i]));
            res.region = pssd_pkg::REGION_SECOND;
        end else begin
            // restoring division gives the projection parameter
            rem = c1;
            t   = '0;
            for (int i = 0; i < pssd_pkg::DIV_STEPS; i++) begin
                rem = rem << 1;
                t   = t << 1;
                if (rem >= c2) begin
                    rem = rem - c2;
                    t[0] = 1'b1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                prod = v[i] * signed'({64'd0, t});
                d[i] = w[i] - (prod >>> 32);
            end
            res.region = pssd_pkg::REGION_INSIDE;
        end
        sum = '0;
        for (int i = 0; i < 3; i++) sum += d[i] * d[i];
        res.distance = floor_sqrt(sum);
        return res;
    endfunction

    // predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        logic signed [COORD_WIDTH-1:0] p [3];
        logic signed [COORD_WIDTH-1:0] a [3];
        logic signed [COORD_WIDTH-1:0] b [3];
        t_dist_item exp_item;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (i_seg.valid && i_seg.ready) begin
                p = '{i_seg.point_x, i_seg.point_y, i_seg.point_z};
                a = '{i_seg.start_x, i_seg.start_y, i_seg.start_z};
                b = '{i_seg.end_x, i_seg.end_y, i_seg.end_z};
                expected_q.push_back(segment_distance(p, a, b));
            end
            if (i_dist.valid && i_dist.ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result item: distance %0h region %0d",
                                 i_dist.distance, i_dist.region);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (exp_item.distance !== i_dist.distance
                            || exp_item.region !== i_dist.region) begin
                        if (fail_count < 10)
                            $display("result differs: exp %0h/%0d got %0h/%0d",
                                     exp_item.distance, exp_item.region,
                                     i_dist.distance, i_dist.region);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CW = pssd_pkg::COORD_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1300;

    typedef logic signed [CW-1:0] t_coord;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   stall_phase;

    pssd_in_if  #(.COORD_WIDTH(CW)) seg_if ();
    pssd_out_if #(.COORD_WIDTH(CW)) dist_if ();

    point_segment_distance_3d #(.COORD_WIDTH(CW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_dist  (dist_if.source)
    );

    pssd_checker #(.COORD_WIDTH(CW)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (seg_if.sink),
        .i_dist       (dist_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // time limit
    initial begin
        #20ms;
        $display("point_segment_distance_3d: mismatch");
        $finish;
    end

    // receiver stalls in phases: free, mostly ready at random, mostly stalled at random
    initial begin
        dist_if.ready = 1'b0;
        stall_phase   = 0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
            case (stall_phase)
                0: dist_if.ready <= 1'b1;
                1: dist_if.ready <= ($urandom_range(0, 6) != 0);
                default: dist_if.ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // random coordinate: full range, small, or edge values
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            1, 2: return t_coord'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input t_coord c [9]);
        seg_if.valid   <= 1'b1;
        seg_if.point_x <= c[0];
        seg_if.point_y <= c[1];
        seg_if.point_z <= c[2];
        seg_if.start_x <= c[3];
        seg_if.start_y <= c[4];
        seg_if.start_z <= c[5];
        seg_if.end_x   <= c[6];
        seg_if.end_y   <= c[7];
        seg_if.end_z   <= c[8];
        do @(posedge i_clk); while (!seg_if.ready);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            seg_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        t_coord c [9];
        t_coord mx;
        t_coord mn;
        int     burst;
        int     wait_cycles;
        mx = t_coord'(32'h7fffffff);
        mn = t_coord'(32'h80000000);
        i_rst_n        = 1'b0;
        seg_if.valid   = 1'b0;
        seg_if.point_x = '0;
        seg_if.point_y = '0;
        seg_if.point_z = '0;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.start_z = '0;
        seg_if.end_x   = '0;
        seg_if.end_y   = '0;
        seg_if.end_z   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items: extremes, degenerate segment, boundaries, each region
        c = '{default: '0};                              send_item(c);
        c = '{mx, mx, mx, mn, mn, mn, mn, mn, mn};       send_item(c);
        c = '{mn, mn, mn, mx, mx, mx, mx, mx, mx};       send_item(c);
        c = '{mx, mn, mx, mn, mx, mn, mx, mn, mx};       send_item(c);
        c = '{mn, mx, mn, mn, mn, mn, mx, mx, mx};       send_item(c);
        c = '{mx, mx, mx, mn, mn, mn, mx, mx, mx};       send_item(c);
        c = '{0, 0, 0, mn, mn, mn, mx, mx, mx};          send_item(c);
        c = '{0, 32'h10000, 0, 0, 0, 0, 32'h20000, 0, 0}; send_item(c);
        c = '{32'h20000, 5, 0, 0, 0, 0, 32'h20000, 0, 0}; send_item(c);
        c = '{32'h10000, 7, 3, 0, 0, 0, 32'h30000, 0, 0}; send_item(c);
        c = '{-5, 9, 0, 0, 0, 0, 32'h30000, 0, 0};       send_item(c);
        c = '{32'h40000, 1, 1, 0, 0, 0, 32'h30000, 0, 0}; send_item(c);
        c = '{1, 2, 3, 1, 1, 1, 1, 1, 1};                send_item(c);
        c = '{mx, 0, mn, 0, 0, 0, 1, 1, 1};              send_item(c);
        c = '{-1, -1, -1, 0, 0, 0, -1, -1, -1};          send_item(c);
        c = '{1, 1, 1, -1, -1, -1, 3, 3, 3};             send_item(c);

        // random items in bursts
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
                for (int j = 0; j < 9; j++) c[j] = rand_coord();
                case ($urandom_range(0, 7))
                    0: for (int j = 0; j < 3; j++) c[6 + j] = c[3 + j];
                    1: for (int j = 0; j < 3; j++) c[j] = c[3 + j];
                    2: for (int j = 0; j < 3; j++) c[j] = c[6 + j];
                    default: ;
                endcase
                send_item(c);
            end
            idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
        end
        seg_if.valid <= 1'b0;

        // drain, then let the pipe settle
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("point_segment_distance_3d: match");
        else
            $display("point_segment_distance_3d: mismatch");
        $finish;
    end

endmodule
